>>> hdl/sre_pkg.sv
`timescale 1ns / 1ps
package sre_pkg;
  localparam int BandCount = 32;
  localparam int BandW = 5;
  localparam int MaxSegment = 4096;
  localparam int SumW = 44;
  localparam int LevelW = 17;
  localparam int RawW = 19;
  localparam logic [LevelW-1:0] LevelOne = 17'd65536;
  localparam logic [1:0] RegSegLen = 2'd0;
  localparam logic [1:0] RegChanCnt = 2'd1;
  localparam logic [1:0] RegGain = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_SQRT = 7'b0000100,
    ST_GAIN = 7'b0001000,
    ST_MIX  = 7'b0010000,
    ST_SCAL = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;
endpackage

>>> hdl/sre_if.sv
`timescale 1ns / 1ps
interface sre_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic end_of_block;
  modport source (output valid, left_sample, right_sample, end_of_block, input ready);
  modport sink (input valid, left_sample, right_sample, end_of_block, output ready);
endinterface

interface sre_out_if;
  logic valid;
  logic ready;
  logic [4:0] band_index;
  logic [16:0] smoothed_level;
  logic [18:0] raw_level;
  modport source (output valid, band_index, smoothed_level, raw_level, input ready);
  modport sink (input valid, band_index, smoothed_level, raw_level, output ready);
endinterface

interface sre_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/segment_rms_envelope_core.sv
`timescale 1ns / 1ps
// segment rms envelope core
// in_ch carries one audio frame per transaction (left, right, end_of_block)
// out_ch carries one transaction per completed band segment
// cfg_ch writes segment_length (0), channel_count (1), level_gain (2)
// a frame that does not close a segment is absorbed in the idle state
// a closing frame keeps the input busy through a 46-step restoring
// divide, a load step and an 18-step square-root loop, then gain,
// smoothing, a reciprocal /10 and the result load
// the band level store is a 32-entry synchronous memory, read at close
// and written back when the result is loaded
// reset restores default registers and zeroes sum, count and band;
// band levels read as zero until first written (valid bit per band)
// out stalls hold the result; frames keep being absorbed meanwhile, and a
// new close waits in its last step until the held result is taken
module segment_rms_envelope_core (
  input logic clk,
  input logic rst_n,
  sre_in_if.sink in_ch,
  sre_out_if.source out_ch,
  sre_cfg_if.sink cfg_ch
);
  localparam int DivW = sre_pkg::SumW + 2;

  logic [12:0] seg_len_r;
  logic [1:0] chan_cnt_r;
  logic [10:0] gain_r;
  logic [sre_pkg::SumW-1:0] sum_r;
  logic [11:0] cnt_r;
  logic [5:0] band_r;
  logic [sre_pkg::BandCount-1:0] vld_r;
  logic [sre_pkg::LevelW-1:0] mem [sre_pkg::BandCount];
  logic [sre_pkg::LevelW-1:0] rd_r;
  sre_pkg::state_t st_r;

  // effective registers
  logic [12:0] seg_eff;
  logic ch2;
  always_comb begin
    seg_eff = seg_len_r;
    if (seg_len_r == 13'd0) seg_eff = 13'd1;
    else if (seg_len_r > 13'(sre_pkg::MaxSegment)) seg_eff = 13'(sre_pkg::MaxSegment);
    ch2 = chan_cnt_r[1];
  end

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r <= 13'd64;
      chan_cnt_r <= 2'd2;
      gain_r <= 11'd896;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sre_pkg::RegSegLen: seg_len_r <= cfg_ch.data;
        sre_pkg::RegChanCnt: chan_cnt_r <= cfg_ch.data[1:0];
        sre_pkg::RegGain: gain_r <= cfg_ch.data[10:0];
        default: ;
      endcase
    end
  end

  // frame accumulate
  logic signed [31:0] sq_l, sq_r;
  logic [sre_pkg::SumW-1:0] sum_nxt;
  logic [12:0] cnt_inc;
  logic closes;
  logic in_acc;
  logic out_load;
  assign sq_l = in_ch.left_sample * in_ch.left_sample;
  assign sq_r = in_ch.right_sample * in_ch.right_sample;
  assign sum_nxt = sum_r + sre_pkg::SumW'(unsigned'(sq_l))
                 + (ch2 ? sre_pkg::SumW'(unsigned'(sq_r)) : '0);
  assign cnt_inc = {1'b0, cnt_r} + 13'd1;
  assign closes = (band_r < 6'(sre_pkg::BandCount)) && (cnt_inc >= seg_eff);
  assign in_ch.ready = (st_r == sre_pkg::ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  // result register is free or being emptied this cycle
  assign out_load = (st_r == sre_pkg::ST_OUT) && (!out_ch.valid || out_ch.ready);

  // datapath regs
  logic [DivW-1:0] num_r;     // dividend shifting, quotient builds here
  logic [DivW-1:0] rem_r;
  logic [14:0] dvs_r;
  logic [5:0] it_r;
  logic [4:0] bidx_r;
  logic [35:0] rad_r;
  logic [17:0] root_r;
  logic [36:0] srem_r;
  logic [18:0] raw_r;
  logic [sre_pkg::LevelW+4:0] mix_r;
  logic [sre_pkg::LevelW-1:0] lvl_r;

  logic [DivW:0] rem_sh;
  assign rem_sh = {rem_r, num_r[DivW-1]};
  logic [37:0] s_try;
  logic [36:0] s_sh;
  assign s_sh = {srem_r[34:0], rad_r[35:34]};
  assign s_try = {1'b0, s_sh} - {18'd0, root_r, 2'b01};

  logic [sre_pkg::LevelW-1:0] old_lvl;
  assign old_lvl = vld_r[bidx_r] ? rd_r : '0;
  // reciprocal of ten, exact over the whole 22-bit mix range
  logic [44:0] q10;
  logic [sre_pkg::LevelW+4:0] lvl_q;
  assign q10 = mix_r * 45'd6710887;
  assign lvl_q = 22'(q10 >> 26);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sre_pkg::ST_IDLE;
      sum_r <= '0;
      cnt_r <= '0;
      band_r <= '0;
      vld_r <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_load) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (st_r)
        sre_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (band_r < 6'(sre_pkg::BandCount)) begin
              sum_r <= sum_nxt;
              cnt_r <= cnt_inc[11:0];
            end
            if (closes) begin
              num_r <= {sum_nxt, 2'b00};
              rem_r <= '0;
              dvs_r <= {1'b0, seg_eff, 1'b0} >> !ch2;
              it_r <= '0;
              bidx_r <= band_r[4:0];
              sum_r <= '0;
              cnt_r <= '0;
              band_r <= band_r + 6'd1;
              st_r <= sre_pkg::ST_DIV;
            end
            if (in_ch.end_of_block) begin
              sum_r <= '0;
              cnt_r <= '0;
              band_r <= '0;
            end
          end
        end
        sre_pkg::ST_DIV: begin
          if (rem_sh >= {{(DivW-14){1'b0}}, dvs_r}) begin
            rem_r <= DivW'(rem_sh - {{(DivW-14){1'b0}}, dvs_r});
            num_r <= {num_r[DivW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[DivW-1:0];
            num_r <= {num_r[DivW-2:0], 1'b0};
          end
          if (it_r == 6'(DivW - 1)) begin
            it_r <= '0;
            st_r <= sre_pkg::ST_SQRT;
          end else begin
            it_r <= it_r + 6'd1;
          end
        end
        sre_pkg::ST_SQRT: begin
          if (it_r == 6'd0) begin
            // quotient saturated to 36 bits keeps sqrt >= 2^17 > clamp
            rad_r <= (|num_r[DivW-1:36]) ? '1 : num_r[35:0];
            root_r <= '0;
            srem_r <= '0;
            it_r <= 6'd1;
          end else begin
            if (!s_try[37]) begin
              srem_r <= s_try[36:0];
              root_r <= {root_r[16:0], 1'b1};
            end else begin
              srem_r <= s_sh;
              root_r <= {root_r[16:0], 1'b0};
            end
            rad_r <= {rad_r[33:0], 2'b00};
            it_r <= it_r + 6'd1;
            if (it_r == 6'd18) st_r <= sre_pkg::ST_GAIN;
          end
        end
        sre_pkg::ST_GAIN: begin
          raw_r <= 19'(((29'((root_r > 18'(sre_pkg::LevelOne)) ? 18'(sre_pkg::LevelOne)
                        : root_r) * 29'(gain_r)) + 29'd128) >> 8);
          st_r <= sre_pkg::ST_MIX;
        end
        sre_pkg::ST_MIX: begin
          if ({2'b0, raw_r} > {4'b0, old_lvl})
            mix_r <= 22'(old_lvl) * 22'd3 + 22'(raw_r) * 22'd7 + 22'd5;
          else
            mix_r <= 22'(old_lvl) * 22'd7 + 22'(raw_r) * 22'd3 + 22'd5;
          st_r <= sre_pkg::ST_SCAL;
        end
        sre_pkg::ST_SCAL: begin
          lvl_r <= (lvl_q > 22'(sre_pkg::LevelOne)) ? sre_pkg::LevelOne
                   : lvl_q[sre_pkg::LevelW-1:0];
          st_r <= sre_pkg::ST_OUT;
        end
        sre_pkg::ST_OUT: begin
          if (out_load) begin
            vld_r[bidx_r] <= 1'b1;
            out_ch.band_index <= bidx_r;
            out_ch.smoothed_level <= lvl_r;
            out_ch.raw_level <= raw_r;
            st_r <= sre_pkg::ST_IDLE;
          end
        end
        default: st_r <= sre_pkg::ST_IDLE;
      endcase
    end
  end

  // band level memory: read at close, written back at result
  always_ff @(posedge clk) begin
    if (out_load) mem[bidx_r] <= lvl_r;
    rd_r <= mem[bidx_r];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != sre_pkg::ST_IDLE) |-> !in_ch.ready)
    else $error("frame accepted during band close");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == sre_pkg::ST_OUT) |=> out_ch.valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.smoothed_level <= sre_pkg::LevelOne)
    else $error("level above one");
  assert property (@(posedge clk) disable iff (!rst_n)
    band_r <= 6'(sre_pkg::BandCount))
    else $error("band counter overran");
endmodule

>>> verif/sre_level_board.sv
`timescale 1ns / 1ps
// tracks the band meter state and the queue of expected band results
class sre_level_board;
  typedef struct packed {
    logic [4:0]  band;
    logic [16:0] level;
    logic [18:0] raw;
  } band_result_t;

  logic [12:0] seg_len_reg;
  logic [1:0]  chan_reg;
  logic [10:0] gain_reg;
  logic [43:0] sum;
  int unsigned frames;
  int unsigned band;
  logic [16:0] levels [32];
  band_result_t pending [$];
  int unsigned errors;

  function new();
    seg_len_reg = 13'd64;
    chan_reg = 2'd2;
    gain_reg = 11'd896;
    sum = '0;
    frames = 0;
    band = 0;
    errors = 0;
    foreach (levels[i]) levels[i] = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [12:0] data);
    case (idx)
      sre_pkg::RegSegLen:  seg_len_reg = data;
      sre_pkg::RegChanCnt: chan_reg = data[1:0];
      sre_pkg::RegGain:    gain_reg = data[10:0];
      default: ;
    endcase
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // note an accepted frame; returns 1 when a band result is expected
  function automatic bit note_frame(logic signed [15:0] l, logic signed [15:0] r, logic eob);
    longint unsigned seg, ch, rms, raw, old, lvl;
    band_result_t res;
    bit hit;
    hit = 0;
    seg = (seg_len_reg == 0) ? 1 : (seg_len_reg > 4096) ? 4096 : seg_len_reg;
    ch = (chan_reg == 0) ? 1 : (chan_reg > 2) ? 2 : chan_reg;
    if (band < sre_pkg::BandCount) begin
      sum = sum + 44'(longint'(l) * longint'(l));
      if (ch == 2) sum = sum + 44'(longint'(r) * longint'(r));
      frames++;
      if (frames >= seg) begin
        rms = isqrt((longint'(sum) * 4) / (seg * ch));
        if (rms > 65536) rms = 65536;
        raw = (rms * gain_reg + 128) >> 8;
        old = levels[band];
        if (raw > old) lvl = (3 * old + 7 * raw + 5) / 10;
        else lvl = (7 * old + 3 * raw + 5) / 10;
        if (lvl > 65536) lvl = 65536;
        levels[band] = lvl[16:0];
        res.band = band[4:0];
        res.level = lvl[16:0];
        res.raw = raw[18:0];
        pending.push_back(res);
        hit = 1;
        sum = '0;
        frames = 0;
        band++;
      end
    end
    if (eob) begin
      sum = '0;
      frames = 0;
      band = 0;
    end
    return hit;
  endfunction

  function void check_result(logic [4:0] b, logic [16:0] lv, logic [18:0] rw);
    band_result_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result band %0d level %0d raw %0d", b, lv, rw);
      return;
    end
    e = pending.pop_front();
    if (e.band !== b || e.level !== lv || e.raw !== rw) begin
      errors++;
      if (errors <= 10)
        $display("mismatch exp band %0d level %0d raw %0d, got band %0d level %0d raw %0d",
                 e.band, e.level, e.raw, b, lv, rw);
    end
  endfunction
endclass

>>> verif/tb_segment_rms_envelope_core.sv
`timescale 1ns / 1ps
module tb_segment_rms_envelope_core;
  logic clk;
  logic rst_n;
  sre_in_if in_ch ();
  sre_out_if out_ch ();
  sre_cfg_if cfg_ch ();

  segment_rms_envelope_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  sre_level_board board;
  // idle controls: percent chance of idling per cycle on each side
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit sink_hold;        // long receiver hold-off request

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // safety limit, well above the slowest legal run
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random ready, long hold when asked, check every result transaction
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_result(out_ch.band_index, out_ch.smoothed_level, out_ch.raw_level);
      out_ch.ready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // receiver hold-off counted in its own process
  task automatic hold_receiver(int unsigned cycles);
    sink_hold = 1;
    repeat (cycles) @(posedge clk);
    sink_hold = 0;
  endtask

  // one write transaction, then valid is lowered and left low on return
  task automatic write_cfg(logic [1:0] idx, logic [12:0] data);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, data);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  // send one frame transaction, with random idle before it; valid stays up
  // afterwards until the next idle cycle or drain
  task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r, logic eob);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.left_sample <= l;
    in_ch.right_sample <= r;
    in_ch.end_of_block <= eob;
    do @(posedge clk); while (!in_ch.ready);
    void'(board.note_frame(l, r, eob));
  endtask

  // wait until all expected results have drained, then let the core settle
  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_ch.valid <= 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  // random sample: mostly full-scale random, sometimes extremes or small
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(255)) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_blocks(int unsigned frames_goal, int unsigned seg);
    int unsigned sent, bands, k;
    sent = 0;
    while (sent < frames_goal) begin
      // mostly well-formed blocks of whole segments, sometimes a partial tail
      bands = $urandom_range(1, 34);
      for (k = 0; k < bands * seg && sent < frames_goal; k++) begin
        send_frame(rand_sample(), rand_sample(), $urandom_range(49) == 0);
        sent++;
      end
      if ($urandom_range(3) != 0) begin
        send_frame(rand_sample(), rand_sample(), 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    int i;
    board = new();
    rst_n = 0;
    sink_hold = 0;
    src_idle_pct = 32;
    snk_idle_pct = 32;
    in_ch.valid = 0;
    in_ch.left_sample = '0;
    in_ch.right_sample = '0;
    in_ch.end_of_block = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = sre_pkg::RegSegLen;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults first with full-scale and zero frames
    send_frame(16'sh8000, 16'sh8000, 1'b0);
    send_frame(16'sh7FFF, 16'sh0000, 1'b1);
    drain();
    // segment length one, mono, max gain: every frame closes a band
    write_cfg(sre_pkg::RegSegLen, 13'd1);
    write_cfg(sre_pkg::RegChanCnt, 13'd1);
    write_cfg(sre_pkg::RegGain, 13'd1280);
    send_frame(16'sh8000, 16'sh1234, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(16'sh0000, 16'sh7FFF, 1'b0);
    send_frame(16'sh0001, 16'shFFFF, 1'b1);
    drain();
    // zero length and zero channel treated as one; gain out of range used as given
    write_cfg(sre_pkg::RegSegLen, 13'd0);
    write_cfg(sre_pkg::RegChanCnt, 13'd0);
    write_cfg(sre_pkg::RegGain, 13'h7FF);
    send_frame(16'sh8000, 16'sh0000, 1'b0);
    send_frame(16'sh4000, 16'sh0000, 1'b1);
    drain();
    // channel count three treated as two, minimum gain
    write_cfg(sre_pkg::RegChanCnt, 13'd3);
    write_cfg(sre_pkg::RegGain, 13'd26);
    send_frame(16'sh8000, 16'sh8000, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b1);
    drain();
    // bands past the last: 34 one-frame segments then end of block
    write_cfg(sre_pkg::RegChanCnt, 13'd2);
    write_cfg(sre_pkg::RegGain, 13'd0);
    for (i = 0; i < 34; i++) send_frame(rand_sample(), rand_sample(), i == 33);
    drain();
    // length above the maximum saturates: a few frames only, then discard
    write_cfg(sre_pkg::RegSegLen, 13'h1FFF);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
    drain();
    // mid-segment change: shrink length to close a segment early
    write_cfg(sre_pkg::RegSegLen, 13'd8);
    write_cfg(sre_pkg::RegGain, 13'd896);
    for (i = 0; i < 5; i++) send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    drain();
    write_cfg(sre_pkg::RegSegLen, 13'd3);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
    drain();

    // pressure: receiver held off while frames keep coming
    write_cfg(sre_pkg::RegSegLen, 13'd1);
    fork
      hold_receiver(600);
    join_none
    for (i = 0; i < 12; i++) send_frame(rand_sample(), rand_sample(), 1'b0);
    drain();

    // random phases with varied settings; burst phase without idling
    write_cfg(sre_pkg::RegSegLen, 13'd2);
    write_cfg(sre_pkg::RegChanCnt, 13'd1);
    write_cfg(sre_pkg::RegGain, 13'd512);
    run_blocks(300, 2);
    drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_cfg(sre_pkg::RegSegLen, 13'd4);
    write_cfg(sre_pkg::RegChanCnt, 13'd2);
    write_cfg(sre_pkg::RegGain, 13'd1280);
    run_blocks(300, 4);
    drain();
    src_idle_pct = 32;
    snk_idle_pct = 32;
    write_cfg(sre_pkg::RegSegLen, 13'd1);
    write_cfg(sre_pkg::RegGain, 13'($urandom_range(26, 1280)));
    run_blocks(350, 1);
    drain();
    write_cfg(sre_pkg::RegSegLen, 13'd16);
    write_cfg(sre_pkg::RegChanCnt, 13'($urandom_range(1, 2)));
    write_cfg(sre_pkg::RegGain, 13'd26);
    run_blocks(300, 16);
    // the final wait until the queue drains
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
